[hdl/greedy_box_nms_defines.svh]
// Assertion macros used by the checker file of the box suppression block.
`ifndef GREEDY_BOX_NMS_DEFINES_SVH
`define GREEDY_BOX_NMS_DEFINES_SVH

// Consequent checked in the same cycle, outside reset.
`define GBN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the following cycle, outside reset.
`define GBN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent checked in the following cycle, reset included.
`define GBN_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/gbn_pkg.sv]
// Package with the box type, cell control type and helpers of the suppression block.
`default_nettype none
package gbn_pkg;

   localparam int GBN_MAX_BOXES = 64;
   localparam logic [15:0] GBN_THR_RESET = 16'd32768;

   typedef struct packed {
      logic [15:0]        score;
      logic signed [15:0] bottom;
      logic signed [15:0] right;
      logic signed [15:0] top;
      logic signed [15:0] left;
   } box_type;

   typedef struct packed {
      logic ins;
      logic shift;
      logic clear;
      logic stage_a;
      logic stage_b;
      logic stage_c;
      logic stage_d;
   } cell_ctrl_type;

   function automatic logic [15:0] span16(input logic signed [15:0] lo,
                                          input logic signed [15:0] hi);
      logic signed [16:0] d;
      d = {hi[15], hi} - {lo[15], lo};
      return (d > 17'sd0) ? d[15:0] : 16'd0;
   endfunction

   function automatic logic signed [15:0] smax(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [15:0] smin(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage
`default_nettype wire

[hdl/gbn_cell.sv]
// One cell of the sorted box chain with its overlap test against the broadcast box.
`default_nettype none
module gbn_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  gbn_pkg::cell_ctrl_type  ctrl,
   input  gbn_pkg::box_type        new_box,
   input  gbn_pkg::box_type        ref_box,
   input  wire [31:0]              ref_area,
   input  wire [15:0]              threshold,
   input  wire                     prev_valid,
   input  wire                     prev_moves,
   input  gbn_pkg::box_type        prev_box,
   input  wire                     next_valid,
   input  wire                     next_removed,
   input  gbn_pkg::box_type        next_box,
   output logic                    valid_o,
   output logic                    removed_o,
   output logic                    moves_o,
   output gbn_pkg::box_type        box_o
);
   import gbn_pkg::*;

   logic        valid_ff, valid_in;
   logic        removed_ff, removed_in;
   box_type     box_ff, box_in;
   logic [15:0] iw_ff, ih_ff, bw_ff, bh_ff;
   logic [31:0] inter_ff, area_ff;
   logic [48:0] prod_ff;
   logic [32:0] uni;
   logic        hit;

   assign moves_o   = valid_ff && (box_ff.score < new_box.score);
   assign valid_o   = valid_ff;
   assign removed_o = removed_ff;
   assign box_o     = box_ff;

   assign uni = {1'b0, ref_area} + {1'b0, area_ff} - {1'b0, inter_ff};
   assign hit = (inter_ff == 32'd0) ? (threshold == 16'd0)
                                    : ({1'b0, inter_ff, 16'd0} >= prod_ff);

   always_comb begin
      valid_in   = valid_ff;
      removed_in = removed_ff;
      box_in     = box_ff;
      if (ctrl.clear) begin
         valid_in   = 1'b0;
         removed_in = 1'b0;
      end else if (ctrl.ins) begin
         if (prev_moves) begin
            valid_in   = 1'b1;
            removed_in = 1'b0;
            box_in     = prev_box;
         end else if (prev_valid && (moves_o || !valid_ff)) begin
            valid_in   = 1'b1;
            removed_in = 1'b0;
            box_in     = new_box;
         end
      end else if (ctrl.shift) begin
         valid_in   = next_valid;
         removed_in = next_removed;
         box_in     = next_box;
      end else if (ctrl.stage_d) begin
         if (valid_ff && hit) begin
            removed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         removed_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         removed_ff <= removed_in;
      end
      box_ff <= box_in;
      if (ctrl.stage_a) begin
         iw_ff <= span16(smax(ref_box.left, box_ff.left), smin(ref_box.right, box_ff.right));
         ih_ff <= span16(smax(ref_box.top, box_ff.top), smin(ref_box.bottom, box_ff.bottom));
         bw_ff <= span16(box_ff.left, box_ff.right);
         bh_ff <= span16(box_ff.top, box_ff.bottom);
      end
      if (ctrl.stage_b) begin
         inter_ff <= iw_ff * ih_ff;
         area_ff  <= bw_ff * bh_ff;
      end
      if (ctrl.stage_c) begin
         prod_ff <= {33'd0, threshold} * {16'd0, uni};
      end
   end

endmodule
`default_nettype wire

[hdl/greedy_box_nms.sv]
// Top level of the greedy box suppression block: cell chain and scan sequencer.
//
//  Channel | Ports  | Contents
//  input   | req_*  | tdata: left, top, right, bottom, score; tlast: last box of the set
//  result  | rsp_*  | tdata: kept edges and score; tlast: last kept box; tuser: boxes dropped
//  config  | csr_*  | overlap threshold, Q0.16
//
// Each accepted box is inserted in sorted place by the cell chain in that same cycle while
// the chain has room. The last box starts the scan, which pops each stored box from the
// chain head and, for each kept box, runs the four-stage overlap test in every cell and
// the result load. Input is not taken during the scan. A stalled result holds the scan.
// Reset is synchronous and clears the chain.
`default_nettype none
module greedy_box_nms #(
   parameter int MAX_BOXES = gbn_pkg::GBN_MAX_BOXES
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [79:0]  req_tdata,   // left, top, right, bottom, score
   input  wire         req_tlast,   // final_box
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [79:0] rsp_tdata,   // kept_left, kept_top, kept_right, kept_bottom, kept_score
   output logic        rsp_tlast,   // end_of_set
   output logic        rsp_tuser,   // dropped_any
   input  wire         csr_we,
   input  wire [15:0]  csr_wdata    // overlap_threshold
);
   import gbn_pkg::*;

   localparam int CW = $clog2(MAX_BOXES + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_POP, ST_CMP_A, ST_CMP_B, ST_CMP_C, ST_CMP_D, ST_EMIT
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic          ovf_ff;
   logic [15:0]   thr_ff;
   box_type       ref_ff;
   logic [15:0]   rw_ff, rh_ff;
   logic [31:0]   rarea_ff;
   logic          rsp_valid_ff, rsp_last_ff, rsp_user_ff;
   box_type       rsp_box_ff;

   cell_ctrl_type ctrl;
   box_type       new_box;
   logic          accept, out_free, any_left;

   logic    [MAX_BOXES-1:0] c_valid, c_removed, c_moves;
   box_type                 c_box [MAX_BOXES];

   assign new_box    = req_tdata;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign any_left   = |(c_valid & ~c_removed);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_box_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      ctrl         = '0;
      ctrl.ins     = accept && (count_ff < CW'(MAX_BOXES));
      ctrl.shift   = (state_ff == ST_POP);
      ctrl.stage_a = (state_ff == ST_CMP_A);
      ctrl.stage_b = (state_ff == ST_CMP_B);
      ctrl.stage_c = (state_ff == ST_CMP_C);
      ctrl.stage_d = (state_ff == ST_CMP_D);
      ctrl.clear   = (state_ff == ST_EMIT) && out_free && !any_left;
   end

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      gbn_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_box      (new_box),
         .ref_box      (ref_ff),
         .ref_area     (rarea_ff),
         .threshold    (thr_ff),
         .prev_valid   ((i == 0) ? 1'b1 : c_valid[(i == 0) ? 0 : i - 1]),
         .prev_moves   ((i == 0) ? 1'b0 : c_moves[(i == 0) ? 0 : i - 1]),
         .prev_box     (c_box[(i == 0) ? 0 : i - 1]),
         .next_valid   ((i == MAX_BOXES - 1) ? 1'b0
                                             : c_valid[(i == MAX_BOXES - 1) ? i : i + 1]),
         .next_removed ((i == MAX_BOXES - 1) ? 1'b0
                                             : c_removed[(i == MAX_BOXES - 1) ? i : i + 1]),
         .next_box     (c_box[(i == MAX_BOXES - 1) ? i : i + 1]),
         .valid_o      (c_valid[i]),
         .removed_o    (c_removed[i]),
         .moves_o      (c_moves[i]),
         .box_o        (c_box[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         thr_ff       <= GBN_THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (ctrl.ins) begin
                     count_ff <= count_ff + CW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     state_ff <= ST_POP;
                  end
               end
            end
            ST_POP: begin
               if (!c_valid[0]) begin
                  state_ff <= ST_IDLE;
               end else if (!c_removed[0]) begin
                  ref_ff   <= c_box[0];
                  state_ff <= ST_CMP_A;
               end
            end
            ST_CMP_A: begin
               rw_ff    <= span16(ref_ff.left, ref_ff.right);
               rh_ff    <= span16(ref_ff.top, ref_ff.bottom);
               state_ff <= ST_CMP_B;
            end
            ST_CMP_B: begin
               rarea_ff <= rw_ff * rh_ff;
               state_ff <= ST_CMP_C;
            end
            ST_CMP_C: begin
               state_ff <= ST_CMP_D;
            end
            ST_CMP_D: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_box_ff   <= ref_ff;
                  rsp_last_ff  <= !any_left;
                  rsp_user_ff  <= ovf_ff;
                  if (any_left) begin
                     state_ff <= ST_POP;
                  end else begin
                     state_ff <= ST_IDLE;
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[hdl/gbn_checker.sv]
// Port checker for the box suppression block and its bind to the top level.
`default_nettype none
`include "greedy_box_nms_defines.svh"
module gbn_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        req_tlast,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [79:0] rsp_tdata
);

   `GBN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled item changed")
   `GBN_ASSERT_NEXT(a_scan_blocks, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input taken during scan")
   `GBN_ASSERT_ALWAYS(a_reset_state, clock, reset, req_tready && !rsp_tvalid, "bad state after reset")

endmodule

bind greedy_box_nms gbn_checker u_gbn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the greedy box suppression block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   class nms_scoreboard;
      logic [63:0] edges_q[$];
      logic [15:0] scores_q[$];
      bit          overflow;
      logic [15:0] threshold;
      logic [82:0] kept_q[$];
      int          mismatches;

      function void clear_set();
         edges_q.delete();
         scores_q.delete();
         overflow = 0;
         threshold = gbn_pkg::GBN_THR_RESET;
         kept_q.delete();
         mismatches = 0;
      endfunction

      function longint span(longint lo, longint hi);
         return (hi > lo) ? hi - lo : 0;
      endfunction

      function longint edge_of(logic [63:0] p, int k);
         logic signed [15:0] v;
         v = p[16*k +: 16];
         return v;
      endfunction

      function bit suppresses(logic [63:0] a, logic [63:0] b);
         longint inter, area_a, area_b, l, t, r, d;
         l = (edge_of(a, 0) > edge_of(b, 0)) ? edge_of(a, 0) : edge_of(b, 0);
         t = (edge_of(a, 1) > edge_of(b, 1)) ? edge_of(a, 1) : edge_of(b, 1);
         r = (edge_of(a, 2) < edge_of(b, 2)) ? edge_of(a, 2) : edge_of(b, 2);
         d = (edge_of(a, 3) < edge_of(b, 3)) ? edge_of(a, 3) : edge_of(b, 3);
         inter = span(l, r) * span(t, d);
         if (inter == 0)
            return threshold == 0;
         area_a = span(edge_of(a, 0), edge_of(a, 2)) * span(edge_of(a, 1), edge_of(a, 3));
         area_b = span(edge_of(b, 0), edge_of(b, 2)) * span(edge_of(b, 1), edge_of(b, 3));
         return (inter * 65536) >= longint'(threshold) * (area_a + area_b - inter);
      endfunction

      function void note_box(logic [79:0] data, logic last);
         int pos;
         bit removed[$];
         int kept_last;
         if (edges_q.size() < gbn_pkg::GBN_MAX_BOXES) begin
            pos = edges_q.size();
            while (pos > 0 && scores_q[pos - 1] < data[79:64])
               pos--;
            edges_q.insert(pos, data[63:0]);
            scores_q.insert(pos, data[79:64]);
         end else begin
            overflow = 1;
         end
         if (!last)
            return;
         for (int i = 0; i < edges_q.size(); i++)
            removed.push_back(0);
         kept_last = -1;
         for (int i = 0; i < edges_q.size(); i++) begin
            if (removed[i])
               continue;
            kept_q.push_back({overflow, 1'b0, 1'b0, scores_q[i], edges_q[i]});
            kept_last = kept_q.size() - 1;
            for (int j = i + 1; j < edges_q.size(); j++)
               if (!removed[j] && suppresses(edges_q[i], edges_q[j]))
                  removed[j] = 1;
         end
         if (kept_last >= 0)
            kept_q[kept_last][81] = 1;
         edges_q.delete();
         scores_q.delete();
         overflow = 0;
      endfunction

      function void check_kept(logic [79:0] data, logic last, logic dropped);
         logic [82:0] want;
         if (kept_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected kept box %h last=%b dropped=%b", data, last, dropped);
            return;
         end
         want = kept_q.pop_front();
         if (want[79:0] !== data || want[81] !== last || want[82] !== dropped) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: kept box expected %h/%b/%b got %h/%b/%b",
                        want[79:0], want[81], want[82], data, last, dropped);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   logic [79:0] req_tdata;   // left, top, right, bottom, score
   logic        req_tlast;   // final_box
   wire         rsp_tvalid;
   logic        rsp_tready;
   wire  [79:0] rsp_tdata;   // kept_left, kept_top, kept_right, kept_bottom, kept_score
   wire         rsp_tlast;   // end_of_set
   wire         rsp_tuser;   // dropped_any
   logic        csr_we;
   logic [15:0] csr_wdata;

   nms_scoreboard board;
   bit          calm;
   bit          timed_out;
   int          quiet_cycles;

   greedy_box_nms dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_box(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_kept(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles > 20000 && !timed_out) begin
         timed_out = 1;
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int burst;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_tready <= 0;
            repeat (burst) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   task automatic send_box(input logic signed [15:0] l, t, r, b, input logic [15:0] s,
                           input logic last);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {s, b, r, t, l};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.kept_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [15:0] value);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.threshold = value;
      @(posedge clock);
   endtask

   task automatic send_random_set(input int count, input bit wild);
      logic signed [15:0] l, t, w, h;
      for (int i = 0; i < count; i++) begin
         if (wild) begin
            send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), i == count - 1);
         end else begin
            l = 16'($urandom_range(0, 400));
            t = 16'($urandom_range(0, 400));
            w = 16'($urandom_range(0, 200));
            h = 16'($urandom_range(0, 200));
            send_box(l, t, l + w, t + h,
                     ($urandom_range(0, 3) == 0) ? 16'(i % 3) * 16'h5555 : 16'($urandom),
                     i == count - 1);
         end
      end
      wait_idle();
   endtask

   initial begin
      logic [15:0] thresholds[6];
      int sets;
      thresholds = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd16384, 16'd50000};
      board = new();
      board.clear_set();
      calm = 0;
      timed_out = 0;
      quiet_cycles = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      csr_we = 0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_box(0, 0, 160, 160, 16'hFFFF, 0);
      send_box(16, 16, 176, 176, 16'hFFFF, 0);
      send_box(800, 800, 900, 900, 16'h8000, 0);
      send_box(10, 10, 5, 5, 16'h0000, 0);
      send_box(-32768, -32768, 32767, 32767, 16'h1234, 0);
      send_box(32767, 32767, -32768, -32768, 16'h1234, 1);
      wait_idle();
      send_box(1, 2, 3, 4, 16'h0001, 1);
      wait_idle();
      set_threshold(16'd0);
      send_box(0, 0, 16, 16, 16'h4000, 0);
      send_box(100, 100, 116, 116, 16'h4000, 0);
      send_box(0, 0, 16, 16, 16'h5000, 1);
      wait_idle();
      set_threshold(16'd65535);
      send_box(0, 0, 16, 16, 16'h4000, 0);
      send_box(0, 0, 16, 16, 16'h4000, 0);
      send_box(0, 0, 17, 16, 16'h3000, 1);
      wait_idle();
      for (int i = 0; i < 66; i++)
         send_box(16'(i * 4), 0, 16'(i * 4 + 40), 40, 16'($urandom), i == 65);
      wait_idle();

      sets = 0;
      while (sets < 12) begin
         set_threshold(thresholds[sets % 6] ^ ((sets >= 6) ? 16'($urandom_range(0, 255)) : 0));
         calm = (sets >= 9);
         send_random_set($urandom_range(1, 12), sets % 5 == 4);
         sets++;
      end
      set_threshold(16'($urandom));
      send_random_set(3, 0);

      if (board.mismatches == 0 && board.kept_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_cell.sv
hdl/greedy_box_nms.sv
hdl/gbn_checker.sv
bench/testbench.sv
